[rtl/core/ecefr_pkg.sv]
package ecefr_pkg;

    // series and fixed-point constants of the sine / cosine evaluation
    localparam int SERIES_TERMS = 10;
    localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
    localparam logic [63:0] PI_QUARTER_Q64 = 64'hC90F_DAA2_2168_C235;

    // pipeline depths
    localparam int MUL_LAT = 2;
    localparam int CELL_LAT = 2 * MUL_LAT + 1;
    localparam int SC_LAT = 1 + MUL_LAT + MUL_LAT + SERIES_TERMS * CELL_LAT + MUL_LAT + 1;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    // data riding along the cell chain
    typedef struct packed {
        logic [61:0] r2;
        logic [61:0] r;
        quad_t       quad;
        logic        refl;
    } sc_side_t;

    // sign of each matrix entry
    typedef struct packed {
        logic nx;
        logic ny;
        logic nz;
        logic ex;
        logic ey;
        logic dx;
        logic dy;
        logic dz;
    } rot_sign_t;

    // one result item
    typedef struct packed {
        logic [31:0] north_x;
        logic [31:0] north_y;
        logic [31:0] north_z;
        logic [31:0] east_x;
        logic [31:0] east_y;
        logic [31:0] down_x;
        logic [31:0] down_y;
        logic [31:0] down_z;
    } rot_mat_t;

endpackage

[rtl/core/ecefr_mul.sv]
module ecefr_mul
    import ecefr_pkg::*;
(
    input  logic         aclk,
    input  logic         ce,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic [127:0] p_reg;
    logic [127:0] p_next;

    // four 32x32 partial products, then one registered sum
    always_ff @(posedge aclk) begin
        if (ce) begin
            pp00_reg <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
            pp01_reg <= {32'b0, a[31:0]} * {32'b0, b[63:32]};
            pp10_reg <= {32'b0, a[63:32]} * {32'b0, b[31:0]};
            pp11_reg <= {32'b0, a[63:32]} * {32'b0, b[63:32]};
        end
    end

    assign p_next = {64'b0, pp00_reg}
                  + ({64'b0, pp01_reg} << 32)
                  + ({64'b0, pp10_reg} << 32)
                  + {pp11_reg, 64'b0};

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/core/ecefr_cell.sv]
module ecefr_cell
    import ecefr_pkg::*;
#(
    parameter int K = 1
) (
    input  logic        aclk,
    input  logic        ce,
    input  logic [62:0] ts_in,
    input  logic [62:0] tc_in,
    input  sc_side_t    side_in,
    output logic [62:0] ts_out,
    output logic [62:0] tc_out,
    output sc_side_t    side_out
);

    // divisors of this series term and their reciprocals, rounded up
    localparam int DS = (2 * K) * (2 * K + 1);
    localparam int DC = (2 * K - 1) * (2 * K);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam logic [127:0] NUM_S = 128'(1) << (62 + LS);
    localparam logic [127:0] NUM_C = 128'(1) << (62 + LC);
    localparam logic [63:0] RECIP_S = 64'((NUM_S + 128'(DS) - 128'(1)) / 128'(DS));
    localparam logic [63:0] RECIP_C = 64'((NUM_C + 128'(DC) - 128'(1)) / 128'(DC));

    logic [127:0] prod_s;
    logic [127:0] prod_c;
    logic [127:0] quo_s;
    logic [127:0] quo_c;
    logic [127:0] quo_s_sh;
    logic [127:0] quo_c_sh;
    logic [62:0]  ts_next;
    logic [62:0]  tc_next;
    logic [62:0]  ts_reg;
    logic [62:0]  tc_reg;
    sc_side_t     side_reg [CELL_LAT];

    // r2 * t in q62
    ecefr_mul u_mul_s (
        .aclk (aclk),
        .ce   (ce),
        .a    ({2'b00, side_in.r2}),
        .b    ({1'b0, ts_in}),
        .p    (prod_s)
    );

    ecefr_mul u_mul_c (
        .aclk (aclk),
        .ce   (ce),
        .a    ({2'b00, side_in.r2}),
        .b    ({1'b0, tc_in}),
        .p    (prod_c)
    );

    // divide by the term constant through its reciprocal
    ecefr_mul u_div_s (
        .aclk (aclk),
        .ce   (ce),
        .a    ({2'b00, prod_s[123:62]}),
        .b    (RECIP_S),
        .p    (quo_s)
    );

    ecefr_mul u_div_c (
        .aclk (aclk),
        .ce   (ce),
        .a    ({2'b00, prod_c[123:62]}),
        .b    (RECIP_C),
        .p    (quo_c)
    );

    assign quo_s_sh = quo_s >> (62 + LS);
    assign quo_c_sh = quo_c >> (62 + LC);
    assign ts_next  = ONE_Q62 - quo_s_sh[62:0];
    assign tc_next  = ONE_Q62 - quo_c_sh[62:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            ts_reg <= ts_next;
            tc_reg <= tc_next;
            side_reg[0] <= side_in;
            for (int i = 1; i < CELL_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign ts_out   = ts_reg;
    assign tc_out   = tc_reg;
    assign side_out = side_reg[CELL_LAT-1];

endmodule

[rtl/core/ecefr_sincos.sv]
module ecefr_sincos
    import ecefr_pkg::*;
#(
    parameter int ANGLE_BITS = 32
) (
    input  logic        aclk,
    input  logic        ce,
    input  logic [31:0] angle,
    output logic [62:0] sin_mag,
    output logic        sin_neg,
    output logic [62:0] cos_mag,
    output logic        cos_neg
);

    logic [63:0]  turn;
    logic [61:0]  g;
    logic [62:0]  h_full;
    logic [61:0]  h_next;
    logic [61:0]  h_reg;
    quad_t        quad_reg;
    logic         refl_reg;

    logic [127:0] prod_r;
    logic [127:0] prod_r2;
    logic [127:0] prod_sr;
    logic [61:0]  r_dly_reg [2];
    quad_t        quad_dly_reg [4];
    logic         refl_dly_reg [4];

    logic [62:0]  ts_chain [SERIES_TERMS+1];
    logic [62:0]  tc_chain [SERIES_TERMS+1];
    sc_side_t     side_chain [SERIES_TERMS+1];

    logic [62:0]  tc_end_reg [2];
    quad_t        quad_end_reg [2];
    logic         refl_end_reg [2];

    logic [62:0]  sr;
    logic [62:0]  s0;
    logic [62:0]  c0;
    logic [62:0]  sin_mag_next;
    logic [62:0]  cos_mag_next;
    logic         sin_neg_next;
    logic         cos_neg_next;
    logic [62:0]  sin_mag_reg;
    logic [62:0]  cos_mag_reg;
    logic         sin_neg_reg;
    logic         cos_neg_reg;

    // angle as a fraction of a full turn, folded into the first octant
    assign turn   = {32'b0, angle} << (64 - ANGLE_BITS);
    assign g      = turn[61:0];
    assign h_full = ONE_Q62 - {1'b0, g};
    assign h_next = g[61] ? h_full[61:0] : g;

    always_ff @(posedge aclk) begin
        if (ce) begin
            quad_reg <= quad_t'(turn[63:62]);
            refl_reg <= g[61];
            h_reg    <= h_next;
        end
    end

    // radians: 2h * pi/4
    ecefr_mul u_rad (
        .aclk (aclk),
        .ce   (ce),
        .a    ({1'b0, h_reg, 1'b0}),
        .b    (PI_QUARTER_Q64),
        .p    (prod_r)
    );

    ecefr_mul u_sq (
        .aclk (aclk),
        .ce   (ce),
        .a    ({2'b00, prod_r[125:64]}),
        .b    ({2'b00, prod_r[125:64]}),
        .p    (prod_r2)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            r_dly_reg[0]    <= prod_r[125:64];
            r_dly_reg[1]    <= r_dly_reg[0];
            quad_dly_reg[0] <= quad_reg;
            refl_dly_reg[0] <= refl_reg;
            for (int i = 1; i < 4; i++) begin
                quad_dly_reg[i] <= quad_dly_reg[i-1];
                refl_dly_reg[i] <= refl_dly_reg[i-1];
            end
        end
    end

    assign ts_chain[0]        = ONE_Q62;
    assign tc_chain[0]        = ONE_Q62;
    assign side_chain[0].r2   = prod_r2[123:62];
    assign side_chain[0].r    = r_dly_reg[1];
    assign side_chain[0].quad = quad_dly_reg[3];
    assign side_chain[0].refl = refl_dly_reg[3];

    // horner chain, highest term first
    for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_cell
        ecefr_cell #(
            .K (SERIES_TERMS - i)
        ) u_cell (
            .aclk     (aclk),
            .ce       (ce),
            .ts_in    (ts_chain[i]),
            .tc_in    (tc_chain[i]),
            .side_in  (side_chain[i]),
            .ts_out   (ts_chain[i+1]),
            .tc_out   (tc_chain[i+1]),
            .side_out (side_chain[i+1])
        );
    end

    // sin r = r * series
    ecefr_mul u_sr (
        .aclk (aclk),
        .ce   (ce),
        .a    ({2'b00, side_chain[SERIES_TERMS].r}),
        .b    ({1'b0, ts_chain[SERIES_TERMS]}),
        .p    (prod_sr)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            tc_end_reg[0]   <= tc_chain[SERIES_TERMS];
            tc_end_reg[1]   <= tc_end_reg[0];
            quad_end_reg[0] <= side_chain[SERIES_TERMS].quad;
            quad_end_reg[1] <= quad_end_reg[0];
            refl_end_reg[0] <= side_chain[SERIES_TERMS].refl;
            refl_end_reg[1] <= refl_end_reg[0];
        end
    end

    assign sr = prod_sr[124:62];

    // undo the octant fold and the quadrant
    always_comb begin
        s0 = refl_end_reg[1] ? tc_end_reg[1] : sr;
        c0 = refl_end_reg[1] ? sr : tc_end_reg[1];
        unique case (quad_end_reg[1])
            QUAD_0: begin
                sin_mag_next = s0;
                sin_neg_next = 1'b0;
                cos_mag_next = c0;
                cos_neg_next = 1'b0;
            end
            QUAD_1: begin
                sin_mag_next = c0;
                sin_neg_next = 1'b0;
                cos_mag_next = s0;
                cos_neg_next = 1'b1;
            end
            QUAD_2: begin
                sin_mag_next = s0;
                sin_neg_next = 1'b1;
                cos_mag_next = c0;
                cos_neg_next = 1'b1;
            end
            default: begin
                sin_mag_next = c0;
                sin_neg_next = 1'b1;
                cos_mag_next = s0;
                cos_neg_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sin_mag_reg <= sin_mag_next;
            sin_neg_reg <= sin_neg_next;
            cos_mag_reg <= cos_mag_next;
            cos_neg_reg <= cos_neg_next;
        end
    end

    assign sin_mag = sin_mag_reg;
    assign sin_neg = sin_neg_reg;
    assign cos_mag = cos_mag_reg;
    assign cos_neg = cos_neg_reg;

endmodule

[rtl/core/ecef_to_ned_rotation_top.sv]
// throughput: one item per cycle while the skid slot is empty, set by the fully
//   pipelined chain of series cells in which every 64-bit product is split into
//   32x32 partial products
// reset: synchronous, active low; clears the valid line and the output stage only,
//   datapath registers keep whatever they hold
module ecef_to_ned_rotation_top
    import ecefr_pkg::*;
#(
    parameter int ANGLE_BITS    = 32,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_latitude,
    input  logic signed [31:0] s_longitude,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_north_x,
    output logic signed [31:0] m_north_y,
    output logic signed [31:0] m_north_z,
    output logic signed [31:0] m_east_x,
    output logic signed [31:0] m_east_y,
    output logic               m_east_z,
    output logic signed [31:0] m_down_x,
    output logic signed [31:0] m_down_y,
    output logic signed [31:0] m_down_z
);

    // pipeline depth up to the rounded entries
    localparam int TOTAL_LAT = SC_LAT + MUL_LAT + 1;

    // rounding to q(OUT_FRAC_BITS), rounded magnitudes stay at or below 1.0
    localparam int RND_W = OUT_FRAC_BITS + 2;
    localparam int PW    = (RND_W > 32) ? RND_W : 32;
    localparam int SH_P  = 60 - OUT_FRAC_BITS;
    localparam int SH_S  = 62 - OUT_FRAC_BITS;
    localparam logic [63:0] RND_P = 64'(1) << (59 - OUT_FRAC_BITS);
    localparam logic [63:0] RND_S = 64'(1) << (61 - OUT_FRAC_BITS);
    localparam logic [RND_W-1:0] ONE_OUT = RND_W'(1) << OUT_FRAC_BITS;

    // product of two q62 magnitudes, high half, rounded half away from zero
    function automatic logic [RND_W-1:0] round_prod(input logic [60:0] hi);
        logic [63:0] sum;
        sum = {3'b000, hi} + RND_P;
        return RND_W'(sum >> SH_P);
    endfunction

    // single q62 magnitude rounded half away from zero
    function automatic logic [RND_W-1:0] round_single(input logic [62:0] m);
        logic [63:0] sum;
        sum = {1'b0, m} + RND_S;
        return RND_W'(sum >> SH_S);
    endfunction

    // saturate to 1.0, apply the sign, keep the 32-bit field
    function automatic logic [31:0] pack_entry(input logic [RND_W-1:0] mag,
                                               input logic neg);
        logic [RND_W-1:0] sat;
        logic [PW-1:0]    ext;
        sat = (mag > ONE_OUT) ? ONE_OUT : mag;
        ext = PW'(sat);
        if (neg) begin
            ext = PW'(0) - ext;
        end
        return ext[31:0];
    endfunction

    // pipeline enable: the whole datapath moves unless the skid slot is taken
    logic ce;

    // valid line that follows items through the datapath
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    // sine and cosine of both angles, magnitude and sign
    logic [62:0] slat_mag;
    logic [62:0] clat_mag;
    logic [62:0] slon_mag;
    logic [62:0] clon_mag;
    logic        slat_neg;
    logic        clat_neg;
    logic        slon_neg;
    logic        clon_neg;

    // full products of the four mixed entries
    logic [127:0] prod_nx;
    logic [127:0] prod_ny;
    logic [127:0] prod_dx;
    logic [127:0] prod_dy;

    // entries taken straight from one trig value, held while the products run
    logic [62:0] nz_dly_reg [MUL_LAT];
    logic [62:0] ex_dly_reg [MUL_LAT];
    logic [62:0] ey_dly_reg [MUL_LAT];
    logic [62:0] dz_dly_reg [MUL_LAT];
    rot_sign_t   sign_next;
    rot_sign_t   sign_dly_reg [MUL_LAT+1];

    // rounded magnitudes
    logic [RND_W-1:0] rnd_nx_reg;
    logic [RND_W-1:0] rnd_ny_reg;
    logic [RND_W-1:0] rnd_nz_reg;
    logic [RND_W-1:0] rnd_ex_reg;
    logic [RND_W-1:0] rnd_ey_reg;
    logic [RND_W-1:0] rnd_dx_reg;
    logic [RND_W-1:0] rnd_dy_reg;
    logic [RND_W-1:0] rnd_dz_reg;

    // output register plus one skid slot
    rot_mat_t push_data;
    rot_mat_t out_reg;
    rot_mat_t skid_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    logic     push;
    logic     pop;
    logic     load_out;
    logic     load_skid;
    logic     out_from_skid;

    assign ce      = !skid_valid_reg;
    assign s_ready = ce;

    // ---------------------------------------------------------------------
    // valid line
    // ---------------------------------------------------------------------
    assign vld_next = {vld_reg[TOTAL_LAT-2:0], s_valid && s_ready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------------
    // trig pipelines, one per angle, identical depth
    // ---------------------------------------------------------------------
    ecefr_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_lat (
        .aclk    (aclk),
        .ce      (ce),
        .angle   (s_latitude),
        .sin_mag (slat_mag),
        .sin_neg (slat_neg),
        .cos_mag (clat_mag),
        .cos_neg (clat_neg)
    );

    ecefr_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_lon (
        .aclk    (aclk),
        .ce      (ce),
        .angle   (s_longitude),
        .sin_mag (slon_mag),
        .sin_neg (slon_neg),
        .cos_mag (clon_mag),
        .cos_neg (clon_neg)
    );

    // ---------------------------------------------------------------------
    // mixed entries: products of unrounded magnitudes
    // ---------------------------------------------------------------------
    ecefr_mul u_mul_nx (
        .aclk (aclk),
        .ce   (ce),
        .a    ({1'b0, slat_mag}),
        .b    ({1'b0, clon_mag}),
        .p    (prod_nx)
    );

    ecefr_mul u_mul_ny (
        .aclk (aclk),
        .ce   (ce),
        .a    ({1'b0, slat_mag}),
        .b    ({1'b0, slon_mag}),
        .p    (prod_ny)
    );

    ecefr_mul u_mul_dx (
        .aclk (aclk),
        .ce   (ce),
        .a    ({1'b0, clat_mag}),
        .b    ({1'b0, clon_mag}),
        .p    (prod_dx)
    );

    ecefr_mul u_mul_dy (
        .aclk (aclk),
        .ce   (ce),
        .a    ({1'b0, clat_mag}),
        .b    ({1'b0, slon_mag}),
        .p    (prod_dy)
    );

    // entry signs; a leading minus in the matrix flips the product sign
    always_comb begin
        sign_next.nx = !(slat_neg ^ clon_neg);
        sign_next.ny = !(slat_neg ^ slon_neg);
        sign_next.nz = clat_neg;
        sign_next.ex = !slon_neg;
        sign_next.ey = clon_neg;
        sign_next.dx = !(clat_neg ^ clon_neg);
        sign_next.dy = !(clat_neg ^ slon_neg);
        sign_next.dz = !slat_neg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            nz_dly_reg[0]   <= clat_mag;
            ex_dly_reg[0]   <= slon_mag;
            ey_dly_reg[0]   <= clon_mag;
            dz_dly_reg[0]   <= slat_mag;
            sign_dly_reg[0] <= sign_next;
            for (int i = 1; i < MUL_LAT; i++) begin
                nz_dly_reg[i] <= nz_dly_reg[i-1];
                ex_dly_reg[i] <= ex_dly_reg[i-1];
                ey_dly_reg[i] <= ey_dly_reg[i-1];
                dz_dly_reg[i] <= dz_dly_reg[i-1];
            end
            for (int i = 1; i <= MUL_LAT; i++) begin
                sign_dly_reg[i] <= sign_dly_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // rounding stage
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ce) begin
            rnd_nx_reg <= round_prod(prod_nx[124:64]);
            rnd_ny_reg <= round_prod(prod_ny[124:64]);
            rnd_dx_reg <= round_prod(prod_dx[124:64]);
            rnd_dy_reg <= round_prod(prod_dy[124:64]);
            rnd_nz_reg <= round_single(nz_dly_reg[MUL_LAT-1]);
            rnd_ex_reg <= round_single(ex_dly_reg[MUL_LAT-1]);
            rnd_ey_reg <= round_single(ey_dly_reg[MUL_LAT-1]);
            rnd_dz_reg <= round_single(dz_dly_reg[MUL_LAT-1]);
        end
    end

    // saturation and sign go straight into the output stage
    always_comb begin
        push_data.north_x = pack_entry(rnd_nx_reg, sign_dly_reg[MUL_LAT].nx);
        push_data.north_y = pack_entry(rnd_ny_reg, sign_dly_reg[MUL_LAT].ny);
        push_data.north_z = pack_entry(rnd_nz_reg, sign_dly_reg[MUL_LAT].nz);
        push_data.east_x  = pack_entry(rnd_ex_reg, sign_dly_reg[MUL_LAT].ex);
        push_data.east_y  = pack_entry(rnd_ey_reg, sign_dly_reg[MUL_LAT].ey);
        push_data.down_x  = pack_entry(rnd_dx_reg, sign_dly_reg[MUL_LAT].dx);
        push_data.down_y  = pack_entry(rnd_dy_reg, sign_dly_reg[MUL_LAT].dy);
        push_data.down_z  = pack_entry(rnd_dz_reg, sign_dly_reg[MUL_LAT].dz);
    end

    // ---------------------------------------------------------------------
    // output register and skid slot
    // a finished item waiting on m_ready does not stop the datapath; only
    // a second waiting item parks in the skid slot and holds the pipeline
    // ---------------------------------------------------------------------
    assign push = ce && vld_reg[TOTAL_LAT-1];
    assign pop  = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg) begin
            // pipeline is frozen, drain the skid slot first
            if (pop) begin
                load_out        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end else begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_skid) begin
            skid_reg <= push_data;
        end
        if (load_out) begin
            out_reg <= out_from_skid ? skid_reg : push_data;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_north_x = out_reg.north_x;
    assign m_north_y = out_reg.north_y;
    assign m_north_z = out_reg.north_z;
    assign m_east_x  = out_reg.east_x;
    assign m_east_y  = out_reg.east_y;
    assign m_east_z  = 1'b0;
    assign m_down_x  = out_reg.down_x;
    assign m_down_y  = out_reg.down_y;
    assign m_down_z  = out_reg.down_z;

endmodule

[bench/ecef_to_ned_rotation_top_tb.sv]
module ecef_to_ned_rotation_top_tb;
    import ecefr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, kept at the defaults the expected values assume
    localparam int ANGLE_W = 32;
    localparam int FRAC_W  = 30;

    // independent copies of the fixed-point constants of the trig series
    localparam logic [63:0] UNIT_Q62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] OCTANT_Q62 = 64'h2000_0000_0000_0000;
    localparam logic [63:0] PI4_Q64    = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] FRAC_ONE   = 64'd1 << FRAC_W;
    localparam int          TERMS      = 10;

    // pipeline depth of the top level, TOTAL_LAT
    localparam int PIPE_DEPTH = 61;
    localparam int ITEM_COUNT = 1050;

    // expected rotation matrices in acceptance order, and the compare against
    // what comes out of the block
    class ned_matrix_board;
        rot_mat_t    matrix_q[$];
        int unsigned mismatches;

        function logic [63:0] prod_hi(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[127:64];
        endfunction

        function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        // sine and cosine of a 64-bit turn as q2.62 magnitude plus sign
        function void turn_sin_cos(input logic [63:0] turn,
                                   output logic [63:0] sn_mag, output bit sn_neg,
                                   output logic [63:0] cs_mag, output bit cs_neg);
            quad_t       quad;
            logic [63:0] g, h, r, r2, ts, tc, sr, s0, c0;
            bit          refl;
            quad = quad_t'(turn[63:62]);
            g    = {2'b00, turn[61:0]};
            // upper half of a quadrant folds back and swaps sine with cosine
            refl = g >= OCTANT_Q62;
            h    = refl ? UNIT_Q62 - g : g;
            r    = prod_hi(h << 1, PI4_Q64);
            r2   = mul_q62(r, r);
            ts   = UNIT_Q62;
            tc   = UNIT_Q62;
            for (int k = TERMS; k >= 1; k--) begin
                ts = UNIT_Q62 - mul_q62(r2, ts) / 64'((2 * k) * (2 * k + 1));
                tc = UNIT_Q62 - mul_q62(r2, tc) / 64'((2 * k - 1) * (2 * k));
            end
            sr = mul_q62(r, ts);
            s0 = refl ? tc : sr;
            c0 = refl ? sr : tc;
            case (quad)
                QUAD_0: begin
                    sn_mag = s0; sn_neg = 1'b0; cs_mag = c0; cs_neg = 1'b0;
                end
                QUAD_1: begin
                    sn_mag = c0; sn_neg = 1'b0; cs_mag = s0; cs_neg = 1'b1;
                end
                QUAD_2: begin
                    sn_mag = s0; sn_neg = 1'b1; cs_mag = c0; cs_neg = 1'b1;
                end
                default: begin
                    sn_mag = c0; sn_neg = 1'b1; cs_mag = s0; cs_neg = 1'b0;
                end
            endcase
        endfunction

        // saturate, then apply sign; a zero magnitude stays zero
        function logic [31:0] signed_entry(logic [63:0] mag, bit neg);
            if (mag > FRAC_ONE)
                mag = FRAC_ONE;
            if (neg)
                mag = 64'd0 - mag;
            return mag[31:0];
        endfunction

        function logic [63:0] round_trig(logic [63:0] m);
            return (m + (64'd1 << (61 - FRAC_W))) >> (62 - FRAC_W);
        endfunction

        function logic [63:0] round_prod(logic [63:0] a, logic [63:0] b);
            return (prod_hi(a, b) + (64'd1 << (59 - FRAC_W))) >> (60 - FRAC_W);
        endfunction

        function void push_angles(logic [31:0] lat, logic [31:0] lon);
            logic [63:0] slat, clat, slon, clon;
            bit          slat_n, clat_n, slon_n, clon_n;
            rot_mat_t    m;
            turn_sin_cos({lat, 32'd0}, slat, slat_n, clat, clat_n);
            turn_sin_cos({lon, 32'd0}, slon, slon_n, clon, clon_n);
            m.north_x = signed_entry(round_prod(slat, clon), slat_n == clon_n);
            m.north_y = signed_entry(round_prod(slat, slon), slat_n == slon_n);
            m.north_z = signed_entry(round_trig(clat), clat_n);
            m.east_x  = signed_entry(round_trig(slon), !slon_n);
            m.east_y  = signed_entry(round_trig(clon), clon_n);
            m.down_x  = signed_entry(round_prod(clat, clon), clat_n == clon_n);
            m.down_y  = signed_entry(round_prod(clat, slon), clat_n == slon_n);
            m.down_z  = signed_entry(round_trig(slat), !slat_n);
            matrix_q.push_back(m);
        endfunction

        function void compare_entry(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t %s: expected %h actual %h", $realtime, label, want, got);
            end
        endfunction

        function void check_matrix(rot_mat_t got, logic east_z);
            rot_mat_t want;
            if (matrix_q.size() == 0) begin
                mismatches++;
                $display("%0t unexpected item: expected none actual %h", $realtime, got);
                return;
            end
            want = matrix_q.pop_front();
            compare_entry("north_x", want.north_x, got.north_x);
            compare_entry("north_y", want.north_y, got.north_y);
            compare_entry("north_z", want.north_z, got.north_z);
            compare_entry("east_x",  want.east_x,  got.east_x);
            compare_entry("east_y",  want.east_y,  got.east_y);
            compare_entry("east_z",  32'd0,        {31'd0, east_z});
            compare_entry("down_x",  want.down_x,  got.down_x);
            compare_entry("down_y",  want.down_y,  got.down_y);
            compare_entry("down_z",  want.down_z,  got.down_z);
        endfunction

        function int pending();
            return matrix_q.size();
        endfunction
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_latitude  = '0;
    logic signed [31:0] s_longitude = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [31:0] m_north_x;
    logic signed [31:0] m_north_y;
    logic signed [31:0] m_north_z;
    logic signed [31:0] m_east_x;
    logic signed [31:0] m_east_y;
    logic               m_east_z;
    logic signed [31:0] m_down_x;
    logic signed [31:0] m_down_y;
    logic signed [31:0] m_down_z;

    ned_matrix_board board = new;

    // phase switches: when set, that side never idles
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;

    always #2 aclk = ~aclk;

    ecef_to_ned_rotation_top #(
        .ANGLE_BITS   (ANGLE_W),
        .OUT_FRAC_BITS(FRAC_W)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_latitude (s_latitude),
        .s_longitude(s_longitude),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_north_x  (m_north_x),
        .m_north_y  (m_north_y),
        .m_north_z  (m_north_z),
        .m_east_x   (m_east_x),
        .m_east_y   (m_east_y),
        .m_east_z   (m_east_z),
        .m_down_x   (m_down_x),
        .m_down_y   (m_down_y),
        .m_down_z   (m_down_z)
    );

    // idle run length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // offer one item, optionally after an idle gap, and hold it until taken
    task automatic send_angles(logic [31:0] lat, logic [31:0] lon);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_latitude  <= lat;
        s_longitude <= lon;
        do @(posedge aclk); while (!s_ready);
        board.push_angles(lat, lon);
    endtask

    // sender holds off until every expected item has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    // angle near a multiple of an eighth turn, where quadrant and fold-back
    // boundaries sit
    function automatic logic [31:0] near_octant();
        logic [31:0] base;
        base = {3'($urandom_range(0, 7)), 29'd0};
        return base + 32'($urandom_range(0, 8)) - 32'd4;
    endfunction

    function automatic logic [31:0] pick_latitude();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return $urandom;                        // any angle, beyond the poles too
        else if (roll < 20)
            return near_octant();
        else
            return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endfunction

    function automatic logic [31:0] pick_longitude();
        if ($urandom_range(0, 99) < 12)
            return near_octant();
        return $urandom;
    endfunction

    // result side: sample the handshake, then choose ready for the next edge
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                board.check_matrix('{north_x: m_north_x, north_y: m_north_y,
                                     north_z: m_north_z, east_x: m_east_x,
                                     east_y: m_east_y, down_x: m_down_x,
                                     down_y: m_down_y, down_z: m_down_z}, m_east_z);
            if (stall_left > 0 && !sink_calm) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready    <= 1'b1;
                stall_left = 0;
                if (!sink_calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // hard stop in case the handshake hangs
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int hold;
        // reset held low from the start, released at a rising edge
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: poles, equator, date line, quadrant and fold-back edges,
        // negative zero entries, latitudes past the poles
        send_angles(32'h0000_0000, 32'h0000_0000);
        send_angles(32'h4000_0000, 32'h0000_0000);
        send_angles(32'hC000_0000, 32'h0000_0000);
        send_angles(32'h0000_0000, 32'h8000_0000);
        send_angles(32'h0000_0000, 32'h7FFF_FFFF);
        send_angles(32'h0000_0000, 32'h4000_0000);
        send_angles(32'h0000_0000, 32'hC000_0000);
        send_angles(32'h4000_0000, 32'h4000_0000);
        send_angles(32'hC000_0000, 32'h8000_0000);
        send_angles(32'h2000_0000, 32'h2000_0000);
        send_angles(32'h1FFF_FFFF, 32'h2000_0001);
        send_angles(32'hE000_0000, 32'h6000_0000);
        send_angles(32'h0000_0001, 32'h0000_0001);
        send_angles(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_angles(32'h3FFF_FFFF, 32'h3FFF_FFFF);
        send_angles(32'hC000_0001, 32'hBFFF_FFFF);
        send_angles(32'h4000_0001, 32'h4000_0001);
        send_angles(32'h7FFF_FFFF, 32'h8000_0001);
        send_angles(32'h8000_0000, 32'hA000_0000);
        send_angles(32'hBFFF_FFFF, 32'h5555_5555);
        send_angles(32'h2AAA_AAAB, 32'hD555_5555);
        send_angles(32'hD555_5555, 32'hAAAA_AAAB);
        drain_results();

        // random part; phases switch off idling on one side or both
        for (int i = 0; i < ITEM_COUNT; i++) begin
            src_calm  = ((i / 100) % 3) == 1;
            sink_calm = ((i / 100) % 4) == 2;
            if (i == 420 || i == 800)
                drain_results();
            send_angles(pick_latitude(), pick_longitude());
        end
        s_valid <= 1'b0;
        src_calm  = 1'b0;
        sink_calm = 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        hold = PIPE_DEPTH + 20;
        repeat (hold) @(posedge aclk);

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
